FILE: rtl/core/positional_list_store_defines.svh
// ----------------------------------------------------------------------------
// positional_list_store_defines
// assertion macros used by the list store checker
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PLS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list store check failed");

// next-cycle implication, disabled while reset is low
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list store check failed");

`endif

FILE: rtl/core/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// types, codes and widths of the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 2;

    // packed widths on the stream ports
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRAVERSE  = 3'd0,
        MODE_INS_FRONT = 3'd1,
        MODE_INS_END   = 3'd2,
        MODE_INS_POS   = 3'd3,
        MODE_DEL_FRONT = 3'd4,
        MODE_DEL_END   = 3'd5,
        MODE_DEL_POS   = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TRAV_RD,
        S_TRAV_OUT,
        S_REPORT
    } state_t;

endpackage

FILE: rtl/core/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// bounded ordered list of signed 32-bit values with positional insert/delete
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata (low bit up)          | tuser       | tlast
//  ----------+-----+-----------------------------+-------------+-------------
//  s_axis    | in  | position[5:0], value[37:6]  | mode[2:0]   | -
//  m_axis    | out | element[31:0], length[37:32]| status[1:0] | last result
//
//  one request at a time; s_axis_tready is high only while the sequencer idles
//  insert/delete: each moved element is read (S_SHIFT_RD), then written (S_SHIFT_WR),
//  through the single read and single write port, then S_REPORT; a refused request
//  goes straight to S_REPORT. traverse: S_TRAV_RD, then S_TRAV_OUT per element; an
//  empty list goes straight to S_REPORT. each request returns to S_IDLE before the
//  next is taken. reset clears the state, element count and output valid only;
//  a stalled m_axis holds the sequencer
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pls_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // position, value, zero pad
    input  logic [pls_pkg::MODE_W-1:0]        s_axis_tuser,  // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pls_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // element, length, zero pad
    output logic [pls_pkg::STATUS_W-1:0]      m_axis_tuser,  // status
    output logic                              m_axis_tlast
);
    import pls_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request fields
    logic [POS_W-1:0]   in_position;
    logic [VALUE_W-1:0] in_value;
    mode_t              in_mode;

    assign in_position = s_axis_tdata[POS_W-1:0];
    assign in_value    = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign in_mode     = mode_t'(s_axis_tuser);

    // sequencer and working registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   j_reg, j_next;        // moving cell index
    logic [IDX_W-1:0]   t_reg, t_next;        // target cell of the request
    logic               ins_reg, ins_next;    // shift direction: insert moves up
    logic [VALUE_W-1:0] value_reg, value_next;
    status_t            status_reg, status_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [VALUE_W-1:0] out_element_reg, out_element_next;
    logic [LEN_W-1:0]   out_length_reg, out_length_next;
    logic               out_last_reg, out_last_next;

    // cell memory, one write and one registered read port
    logic [VALUE_W-1:0] cells_mem [CAPACITY];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [VALUE_W-1:0] rd_data_reg;

    logic in_accept;
    logic out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // shared index stepper: one add/subtract serves shifts and traversal
    logic [CNT_W-1:0] j_ext;
    logic [CNT_W-1:0] step_ext;
    logic             shift_done;
    logic             trav_last;

    assign j_ext      = CNT_W'(j_reg);
    assign step_ext   = ins_reg ? (j_ext - CNT_W'(1)) : (j_ext + CNT_W'(1));
    assign shift_done = ins_reg ? (j_reg == t_reg) : (step_ext >= count_reg);
    assign trav_last  = (step_ext == count_reg);

    // request decode against the current length
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             list_full;
    logic             list_empty;
    logic             ins_pos_ok;
    logic             del_pos_ok;
    logic [IDX_W-1:0] pos_idx;
    state_t           dec_state;
    status_t          dec_status;
    logic [IDX_W-1:0] dec_target;

    assign pos_ext    = CMP_W'(in_position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign list_full  = (count_reg >= CNT_W'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_idx    = IDX_W'(pos_ext - CMP_W'(1));

    always_comb
    begin
        dec_state  = S_REPORT;
        dec_status = ST_OK;
        dec_target = '0;
        unique case (in_mode) inside
            MODE_TRAVERSE:
            begin
                if (list_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_state = S_TRAV_RD;
                end
            end
            MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS:
            begin
                if (list_full)
                begin
                    dec_status = ST_FULL;
                end
                else if (in_mode == MODE_INS_POS && !ins_pos_ok)
                begin
                    dec_status = ST_BADPOS;
                end
                else
                begin
                    dec_state = S_SHIFT_RD;
                    if (in_mode == MODE_INS_END)
                        dec_target = IDX_W'(count_reg);
                    else if (in_mode == MODE_INS_POS)
                        dec_target = pos_idx;
                end
            end
            MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_POS:
            begin
                if (list_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (in_mode == MODE_DEL_POS && !del_pos_ok)
                begin
                    dec_status = ST_BADPOS;
                end
                else
                begin
                    dec_state = S_SHIFT_RD;
                    if (in_mode == MODE_DEL_END)
                        dec_target = IDX_W'(count_reg - CNT_W'(1));
                    else if (in_mode == MODE_DEL_POS)
                        dec_target = pos_idx;
                end
            end
            default:
            begin
                // undefined mode: dropped, no result
                dec_state = S_IDLE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = dec_state;
            end
            S_SHIFT_RD:
            begin
                state_next = shift_done ? S_REPORT : S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_TRAV_RD:
            begin
                state_next = S_TRAV_OUT;
            end
            S_TRAV_OUT:
            begin
                if (out_free)
                    state_next = trav_last ? S_IDLE : S_TRAV_RD;
            end
            S_REPORT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        s_axis_tready    = 1'b0;
        count_next       = count_reg;
        j_next           = j_reg;
        t_next           = t_reg;
        ins_next         = ins_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        mem_we           = 1'b0;
        mem_waddr        = j_reg;
        mem_wdata        = rd_data_reg;
        mem_raddr        = j_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_element_next = out_element_reg;
        out_length_next  = out_length_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    value_next  = in_value;
                    status_next = dec_status;
                    t_next      = dec_target;
                    if (in_mode == MODE_TRAVERSE)
                    begin
                        j_next   = '0;
                        ins_next = 1'b0;
                    end
                    else
                    begin
                        ins_next = (in_mode == MODE_INS_FRONT) ||
                                   (in_mode == MODE_INS_END) ||
                                   (in_mode == MODE_INS_POS);
                        // insert walks down from the end, delete up from the target
                        j_next   = ins_next ? IDX_W'(count_reg) : dec_target;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                mem_raddr = IDX_W'(step_ext);
                if (shift_done)
                begin
                    if (ins_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = t_reg;
                        mem_wdata  = value_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = rd_data_reg;
                j_next    = IDX_W'(step_ext);
            end
            S_TRAV_RD:
            begin
                mem_raddr = j_reg;
            end
            S_TRAV_OUT:
            begin
                mem_raddr = j_reg;
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = ST_OK;
                    out_element_next = rd_data_reg;
                    out_length_next  = LEN_W'(count_reg);
                    out_last_next    = trav_last;
                    j_next           = IDX_W'(step_ext);
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_element_next = '0;
                    out_length_next  = LEN_W'(count_reg);
                    out_last_next    = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        j_reg           <= j_next;
        t_reg           <= t_next;
        ins_reg         <= ins_next;
        value_reg       <= value_next;
        status_reg      <= status_next;
        out_status_reg  <= out_status_next;
        out_element_reg <= out_element_next;
        out_length_reg  <= out_length_next;
        out_last_reg    <= out_last_next;
    end

    // cell memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cells_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= cells_mem[mem_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - LEN_W - VALUE_W){1'b0}},
                            out_length_reg, out_element_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: rtl/core/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker
// port-level checks on the positional list store
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module pls_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [pls_pkg::MODE_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pls_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [pls_pkg::STATUS_W-1:0]  m_axis_tuser,
    input logic                          m_axis_tlast
);
    import pls_pkg::*;

    logic s_fire;
    logic m_stall;
    logic m_fail;

    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign m_fail  = m_axis_tvalid && (m_axis_tuser != ST_OK);

    // a held result stays offered
    `PLS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_stall, m_axis_tvalid)

    // any defined request keeps the sequencer busy in the following cycle
    `PLS_ASSERT_NEXT(a_busy_after_req, clk, rst_n,
        s_fire && (s_axis_tuser <= MODE_DEL_POS), !s_axis_tready)

    // an error status is always the single, final result of its request
    `PLS_ASSERT_SAME(a_fail_is_last, clk, rst_n, m_fail,
        m_axis_tlast && (m_axis_tdata[VALUE_W-1:0] == '0))

    // an empty report always carries a zero length
    `PLS_ASSERT_SAME(a_empty_len, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY),
        m_axis_tdata[VALUE_W+LEN_W-1:VALUE_W] == '0)

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
